// File: sv/lz77te_pkg.sv
// shared types for the lz77 token encoder: beat payloads and window control
// no dependencies
package lz77te_pkg;

   // input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_type;

   // result beat
   typedef struct packed {
      logic [4:0] distance;
      logic [2:0] match_length;
      logic [7:0] next_byte;
      logic       run_last;
      logic       final_token;
   } rsp_type;

   // commands from the encoder control to the search window
   typedef struct packed {
      logic       scan_start;
      logic       push;
      logic [7:0] push_byte;
      logic       clear;
   } win_ctrl_type;

   // byte stream from the search window during a scan
   typedef struct packed {
      logic       byte_valid;
      logic       byte_last;
      logic [7:0] byte_val;
   } win_stat_type;

endpackage

// File: sv/lz77_token_encoder.sv
// top level of the lz77 token encoder: look-ahead lanes, match tracking, token output
// depends on lz77te_pkg and lz77te_window
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | req_data (in_byte, stream_end)
//   rsp     | out       | rsp_valid/rsp_ready   | rsp_data (distance .. final_token)
//
// a byte that neither fills the look-ahead nor ends the stream is stored without a scan
// a token takes a window scan (one memory read per position)
// plus an emit step and match_length + 1 window writes
// reset empties look-ahead and window; unwritten window slots read as zero, no clear pass
// a held result keeps the next token waiting in emit, and the input waits with it
module lz77_token_encoder #(
   parameter int SEARCH_SIZE    = 16,
   parameter int LOOKAHEAD_SIZE = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lz77te_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lz77te_pkg::rsp_type rsp_data
);
   import lz77te_pkg::*;

   localparam int FW = $clog2(LOOKAHEAD_SIZE + 1);
   localparam int LW = $clog2(LOOKAHEAD_SIZE);
   localparam int PW = (SEARCH_SIZE > 1) ? $clog2(SEARCH_SIZE) : 1;
   localparam int CW = $clog2(SEARCH_SIZE + 1);
   localparam int DW = (CW > 5) ? CW : 5;
   localparam int MW = (LW > 3) ? LW : 3;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_SHIFT = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [7:0]                la_ff [LOOKAHEAD_SIZE];
   logic [7:0]                la_in [LOOKAHEAD_SIZE];
   logic                      end_ff, end_in;
   logic [LOOKAHEAD_SIZE-1:0] alive_ff, alive_in;
   logic [LOOKAHEAD_SIZE-1:0] new_v;
   logic [LW-1:0]             best_ff, best_in;
   logic [PW-1:0]             pos_ff, pos_in;
   logic [PW-1:0]             p_ff, p_in;
   logic [FW-1:0]             shift_ff, shift_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]             cap;
   logic [FW-1:0]             remain;
   logic                      hit;
   logic                      go_scan;
   logic [DW-1:0]             dist_w;
   logic [MW-1:0]             len_w;
   win_ctrl_type              win_ctrl;
   win_stat_type              win_stat;

   lz77te_window #(
      .SEARCH_SIZE(SEARCH_SIZE)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .stat  (win_stat)
   );

   // match lanes: lane k extends a candidate that already matched k-1 bytes
   assign cap = fill_ff - FW'(1);
   always_comb begin
      new_v[0] = 1'b0;
      for (int k = 1; k < LOOKAHEAD_SIZE; k++) begin
         if (k == 1) begin
            new_v[k] = (win_stat.byte_val == la_ff[0]) && (FW'(k) <= cap);
         end else begin
            new_v[k] = alive_ff[k-1] && (win_stat.byte_val == la_ff[k-1]) &&
                       (FW'(k) <= cap);
         end
      end
   end

   // a candidate reaching best+1 first is the earliest one that long
   assign hit    = new_v[best_ff + LW'(1)];
   assign remain = fill_ff - FW'(best_ff) - FW'(1);
   assign dist_w = DW'(SEARCH_SIZE) - DW'(pos_ff);
   assign len_w  = MW'(best_ff);

   // control sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      la_in        = la_ff;
      end_in       = end_ff;
      alive_in     = alive_ff;
      best_in      = best_ff;
      pos_in       = pos_ff;
      p_in         = p_ff;
      shift_in     = shift_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      go_scan      = 1'b0;
      win_ctrl     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               la_in[fill_ff[LW-1:0]] = req_data.in_byte;
               fill_in = fill_ff + FW'(1);
               end_in  = req_data.stream_end;
               if (req_data.stream_end || (fill_in == FW'(LOOKAHEAD_SIZE))) begin
                  go_scan  = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (win_stat.byte_valid) begin
               alive_in = new_v;
               p_in     = p_ff + PW'(1);
               if (hit) begin
                  best_in = best_ff + LW'(1);
                  pos_in  = p_ff - PW'(best_ff);
               end
               if (win_stat.byte_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.distance     = (best_ff != '0) ? dist_w[4:0] : 5'd0;
               rsp_in.match_length = len_w[2:0];
               rsp_in.next_byte    = la_ff[best_ff];
               rsp_in.run_last     = !end_ff || (remain == '0);
               rsp_in.final_token  = end_ff && (remain == '0);
               rsp_valid_in        = 1'b1;
               shift_in            = FW'(best_ff) + FW'(1);
               state_in            = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // slide one byte from the look-ahead into the window
            win_ctrl.push      = 1'b1;
            win_ctrl.push_byte = la_ff[0];
            for (int k = 0; k < LOOKAHEAD_SIZE - 1; k++) begin
               la_in[k] = la_ff[k+1];
            end
            fill_in  = fill_ff - FW'(1);
            shift_in = shift_ff - FW'(1);
            if (shift_ff == FW'(1)) begin
               if (!end_ff) begin
                  state_in = ST_IDLE;
               end else if (fill_ff == FW'(1)) begin
                  win_ctrl.clear = 1'b1;
                  end_in         = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  go_scan  = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // fresh search state for each token
      if (go_scan) begin
         win_ctrl.scan_start = 1'b1;
         alive_in = '0;
         best_in  = '0;
         pos_in   = '0;
         p_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and search registers
   always_ff @(posedge clock) begin
      la_ff    <= la_in;
      alive_ff <= alive_in;
      best_ff  <= best_in;
      pos_ff   <= pos_in;
      p_ff     <= p_in;
      shift_ff <= shift_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(LOOKAHEAD_SIZE))
      else $error("look-ahead fill past its size");
   a_scan_only: assert property (@(posedge clock) disable iff (reset)
      win_stat.byte_valid |-> (state_ff == ST_SCAN))
      else $error("window byte outside a scan");
   a_end_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.stream_end) |=> (state_ff == ST_SCAN))
      else $error("final beat did not start a flush");
   a_final_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.final_token) |-> rsp_ff.run_last)
      else $error("final token without run_last");
   a_best_within_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (FW'(best_ff) < fill_ff))
      else $error("match length leaves no next byte");

endmodule

// File: sv/lz77te_window.sv
// search window of the lz77 token encoder: circular byte memory with fill count
// depends on lz77te_pkg
module lz77te_window #(
   parameter int SEARCH_SIZE = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lz77te_pkg::win_ctrl_type ctrl,
   output lz77te_pkg::win_stat_type stat
);
   import lz77te_pkg::*;

   localparam int AW = (SEARCH_SIZE > 1) ? $clog2(SEARCH_SIZE) : 1;
   localparam int CW = $clog2(SEARCH_SIZE + 1);

   logic [7:0]    mem [SEARCH_SIZE];
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          scanning_ff, scanning_in;
   logic [7:0]    rd_data_ff;
   logic          vld_ff, vld_in;
   logic          last_ff, last_in;
   logic          zero_ff, zero_in;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
      logic [AW-1:0] r;
      r = (ptr == AW'(SEARCH_SIZE - 1)) ? '0 : ptr + AW'(1);
      return r;
   endfunction

   // byte memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[head_ff] <= ctrl.push_byte;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   // write pointer and fill count; slots never written read as zero
   always_comb begin
      head_in = head_ff;
      cnt_in  = cnt_ff;
      if (ctrl.clear) begin
         head_in = '0;
         cnt_in  = '0;
      end else if (ctrl.push) begin
         head_in = wrap_inc(head_ff);
         if (cnt_ff != CW'(SEARCH_SIZE)) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   // scan sequencer: oldest to newest, one read per cycle
   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      issue_in    = issue_ff;
      scanning_in = scanning_ff;
      vld_in      = 1'b0;
      last_in     = 1'b0;
      zero_in     = 1'b0;
      if (ctrl.scan_start) begin
         // oldest slot, counting a push in this same cycle
         rd_ptr_in   = head_in;
         issue_in    = '0;
         scanning_in = 1'b1;
      end else if (scanning_ff) begin
         vld_in    = 1'b1;
         last_in   = (issue_ff == CW'(SEARCH_SIZE - 1));
         zero_in   = (issue_ff < (CW'(SEARCH_SIZE) - cnt_ff));
         rd_ptr_in = wrap_inc(rd_ptr_ff);
         issue_in  = issue_ff + CW'(1);
         if (last_in) begin
            scanning_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         cnt_ff      <= '0;
         rd_ptr_ff   <= '0;
         issue_ff    <= '0;
         scanning_ff <= 1'b0;
         vld_ff      <= 1'b0;
         last_ff     <= 1'b0;
         zero_ff     <= 1'b0;
      end else begin
         head_ff     <= head_in;
         cnt_ff      <= cnt_in;
         rd_ptr_ff   <= rd_ptr_in;
         issue_ff    <= issue_in;
         scanning_ff <= scanning_in;
         vld_ff      <= vld_in;
         last_ff     <= last_in;
         zero_ff     <= zero_in;
      end
   end

   // scan output
   assign stat.byte_valid = vld_ff;
   assign stat.byte_last  = last_ff;
   assign stat.byte_val   = zero_ff ? 8'd0 : rd_data_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(SEARCH_SIZE))
      else $error("window fill count past window size");
   a_no_push_in_scan: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !scanning_ff)
      else $error("window write during scan");
   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && last_ff) |=> !vld_ff)
      else $error("scan output after last byte");

endmodule

// File: bench/testbench.sv
// self-checking bench for lz77_token_encoder: directed table, then random byte streams
// predicts tokens with its own sliding-window encoder; depends on lz77te_pkg and the rtl
module testbench;
   import lz77te_pkg::*;

   localparam int SEARCH_DEPTH = 16;
   localparam int AHEAD_DEPTH  = 8;
   localparam int HOLD_LEN     = 400;
   localparam int DRAIN_CYCLES = 4 * (SEARCH_DEPTH + 3 + AHEAD_DEPTH);
   localparam int LIMIT_CYCLES = 2000000;
   localparam int PHASE_ITEMS  = 88;

   // one row of the directed table; tok is used only when typed is set
   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
      logic       typed;
      rsp_type    tok;
   } stim_row_type;

   localparam rsp_type NO_TOKEN = '0;

   localparam stim_row_type DIRECTED_ROWS [21] = '{
      // end on the very first byte: a lone literal closes the stream
      '{8'hA5, 1'b1, 1'b1, '{5'd0, 3'd0, 8'hA5, 1'b1, 1'b1}},
      // eight zeros match the zeroed window at its oldest slot
      '{8'h00, 1'b0, 1'b0, NO_TOKEN},
      '{8'h00, 1'b0, 1'b0, NO_TOKEN},
      '{8'h00, 1'b0, 1'b0, NO_TOKEN},
      '{8'h00, 1'b0, 1'b0, NO_TOKEN},
      '{8'h00, 1'b0, 1'b0, NO_TOKEN},
      '{8'h00, 1'b0, 1'b0, NO_TOKEN},
      '{8'h00, 1'b0, 1'b0, NO_TOKEN},
      '{8'h00, 1'b0, 1'b1, '{5'd16, 3'd7, 8'h00, 1'b1, 1'b0}},
      // final byte into an empty look-ahead
      '{8'hFF, 1'b1, 1'b1, '{5'd0, 3'd0, 8'hFF, 1'b1, 1'b1}},
      // walking ones: a literal once full, then a flush of eight
      '{8'h01, 1'b0, 1'b0, NO_TOKEN},
      '{8'h02, 1'b0, 1'b0, NO_TOKEN},
      '{8'h04, 1'b0, 1'b0, NO_TOKEN},
      '{8'h08, 1'b0, 1'b0, NO_TOKEN},
      '{8'h10, 1'b0, 1'b0, NO_TOKEN},
      '{8'h20, 1'b0, 1'b0, NO_TOKEN},
      '{8'h40, 1'b0, 1'b0, NO_TOKEN},
      '{8'h80, 1'b0, 1'b1, '{5'd0, 3'd0, 8'h01, 1'b1, 1'b0}},
      '{8'hFF, 1'b1, 1'b0, NO_TOKEN},
      // short stream with a repeated byte
      '{8'hAB, 1'b0, 1'b0, NO_TOKEN},
      '{8'hAB, 1'b1, 1'b0, NO_TOKEN}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // idling knobs and the long receiver hold
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_armed = 1'b0;
   int   hold_cycles = 0;

   int   failures = 0;
   int   cycle_count = 0;

   // predictor state: sliding window and look-ahead
   logic [7:0] hist_win [SEARCH_DEPTH];
   logic [7:0] ahead_buf [AHEAD_DEPTH];
   int         ahead_count;

   rsp_type expected_tokens [$];

   lz77_token_encoder #(
      .SEARCH_SIZE   (SEARCH_DEPTH),
      .LOOKAHEAD_SIZE(AHEAD_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // empty window and look-ahead, as after reset or a finished stream
   function automatic void clear_window();
      foreach (hist_win[i]) hist_win[i] = 8'h00;
      foreach (ahead_buf[i]) ahead_buf[i] = 8'h00;
      ahead_count = 0;
   endfunction

   // longest earliest match over the window, then slide by length plus one
   function automatic rsp_type cut_token();
      rsp_type tok;
      int cap, best_len, best_pos, len, shift;
      cap = ahead_count - 1;
      best_len = 0;
      best_pos = 0;
      for (int p = 0; p < SEARCH_DEPTH; p++) begin
         len = 0;
         while (len < cap && p + len < SEARCH_DEPTH && hist_win[p + len] == ahead_buf[len])
            len++;
         if (len > best_len) begin
            best_len = len;
            best_pos = p;
         end
      end
      tok.distance     = (best_len != 0) ? 5'(SEARCH_DEPTH - best_pos) : 5'd0;
      tok.match_length = 3'(best_len);
      tok.next_byte    = ahead_buf[best_len];
      tok.run_last     = 1'b0;
      tok.final_token  = 1'b0;
      shift = best_len + 1;
      for (int k = 0; k < shift; k++) begin
         for (int j = 0; j < SEARCH_DEPTH - 1; j++) hist_win[j] = hist_win[j + 1];
         hist_win[SEARCH_DEPTH - 1] = ahead_buf[k];
      end
      for (int k = 0; k < ahead_count - shift; k++) ahead_buf[k] = ahead_buf[k + shift];
      ahead_count -= shift;
      return tok;
   endfunction

   // tokens caused by one accepted byte
   function automatic void encode_byte(input req_type beat, output rsp_type toks[$]);
      rsp_type tok;
      toks.delete();
      if (ahead_count < AHEAD_DEPTH) begin
         ahead_buf[ahead_count] = beat.in_byte;
         ahead_count++;
      end
      if (!beat.stream_end) begin
         if (ahead_count >= AHEAD_DEPTH) begin
            tok = cut_token();
            tok.run_last = 1'b1;
            toks.push_back(tok);
         end
      end else begin
         while (ahead_count > 0) toks.push_back(cut_token());
         if (toks.size() != 0) begin
            toks[toks.size() - 1].run_last    = 1'b1;
            toks[toks.size() - 1].final_token = 1'b1;
         end
         clear_window();
      end
   endfunction

   // offer one beat, predict its tokens once it is taken
   task automatic offer_beat(input req_type beat, input logic typed, input rsp_type typed_tok);
      rsp_type toks [$];
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      encode_byte(beat, toks);
      if (typed) begin
         toks.delete();
         toks.push_back(typed_tok);
      end
      foreach (toks[i]) expected_tokens.push_back(toks[i]);
   endtask

   // whole streams: mostly periodic text over a small alphabet, some raw noise
   task automatic send_streams(input int item_goal);
      logic [7:0] recent [16];
      logic [7:0] alphabet [4];
      req_type beat;
      int sent, stream_len, depth, period, pick;
      logic [7:0] b;
      sent = 0;
      while (sent < item_goal) begin
         stream_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                                  : $urandom_range(1, 24);
         foreach (alphabet[i])
            alphabet[i] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         period = $urandom_range(1, 12);
         depth = 0;
         for (int k = 0; k < stream_len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 && depth >= period)
               b = recent[period - 1];
            else if (pick < 80)
               b = alphabet[$urandom_range(0, 3)];
            else
               b = 8'($urandom_range(0, 255));
            for (int j = 15; j > 0; j--) recent[j] = recent[j - 1];
            recent[0] = b;
            depth++;
            beat.in_byte    = b;
            beat.stream_end = (k == stream_len - 1);
            offer_beat(beat, 1'b0, NO_TOKEN);
            sent++;
         end
      end
   endtask

   // result side: random stalls plus one long hold counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_armed && hold_cycles < HOLD_LEN) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // compare each accepted token with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            if (failures < 10)
               $display("unexpected token: dist %0d len %0d next %02h last %b final %b",
                        rsp_data.distance, rsp_data.match_length, rsp_data.next_byte,
                        rsp_data.run_last, rsp_data.final_token);
            failures++;
         end else begin
            want = expected_tokens.pop_front();
            if (want.distance !== rsp_data.distance ||
                want.match_length !== rsp_data.match_length ||
                want.next_byte !== rsp_data.next_byte ||
                want.run_last !== rsp_data.run_last ||
                want.final_token !== rsp_data.final_token) begin
               if (failures < 10)
                  $display({"token mismatch: expected dist %0d len %0d next %02h last %b ",
                            "final %b, got dist %0d len %0d next %02h last %b final %b"},
                           want.distance, want.match_length, want.next_byte,
                           want.run_last, want.final_token,
                           rsp_data.distance, rsp_data.match_length, rsp_data.next_byte,
                           rsp_data.run_last, rsp_data.final_token);
               failures++;
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // main sequence
   initial begin
      req_type beat;
      clear_window();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling
      foreach (DIRECTED_ROWS[i]) begin
         beat.in_byte    = DIRECTED_ROWS[i].in_byte;
         beat.stream_end = DIRECTED_ROWS[i].stream_end;
         offer_beat(beat, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].tok);
      end

      // random phases; each ends with the sender waiting for every token
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               hold_armed    <= 1'b1;
            end
            1: begin
               send_idle_pct  = 60;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 60;
            end
            default: begin
               send_idle_pct  = 9;
               recv_stall_pct = 9;
            end
         endcase
         send_streams(PHASE_ITEMS);
         req_valid <= 1'b0;
         while (expected_tokens.size() != 0) @(posedge clock);
      end

      // drain and look for stray tokens
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_tokens.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: lz77_token_encoder.f
sv/lz77te_pkg.sv
sv/lz77te_window.sv
sv/lz77_token_encoder.sv
bench/testbench.sv
